/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the sorted priority queue: opcodes, status
// codes and the per-cycle command that is broadcast along the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int TAG_BITS_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int STATUS_BITS       = 2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. On insert it keeps its entry, takes the new
// item or takes its left neighbour's entry; on removal it takes the right
// neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int IDX    = 0,
  parameter int CNT_W  = 5,
  parameter int TAG_W  = 16,
  parameter int PRIO_W = 8
) (
  input  logic               clk,
  input  spq_pkg::spq_ctl_t  ctl,
  input  logic [CNT_W-1:0]   count,
  input  logic [TAG_W-1:0]   new_tag,
  input  logic [PRIO_W-1:0]  new_prio,
  input  logic               left_lower,
  input  logic [TAG_W-1:0]   left_tag,
  input  logic [PRIO_W-1:0]  left_prio,
  input  logic [TAG_W-1:0]   right_tag,
  input  logic [PRIO_W-1:0]  right_prio,
  output logic               lower,
  output logic [TAG_W-1:0]   tag,
  output logic [PRIO_W-1:0]  prio
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [TAG_W-1:0]  tag_r,  tag_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              occupied;

  assign occupied = IDX_C < count;
  assign lower    = !occupied || (prio_r < new_prio);
  assign tag      = tag_r;
  assign prio     = prio_r;

  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctl.deq) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end else if (ctl.enq && lower) begin
      if (left_lower) begin
        tag_nxt  = left_tag;
        prio_nxt = left_prio;
      end else begin
        tag_nxt  = new_tag;
        prio_nxt = new_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

endmodule

/* sv/sorted_priority_queue_top.sv */
// The result of an item appears on the out_ ports in the cycle after it is taken.
// Throughput: one item per cycle while busy is low; insert and removal finish in a single step of the cell row.
// busy is high during reset, is cleared once reset is released, and stays low from then on.
// Results are strobed by out_valid for exactly one cycle; the receiver cannot stall.
// Reset clears the entry count; slot contents are left as they are.
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept sorted in a row of cells, highest priority at
// the head, equal priorities leaving in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int CNT_W         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [TAG_BITS-1:0]             in_task_tag,
  input  logic [PRIORITY_BITS-1:0]        in_task_priority,
  output logic                            out_valid,
  output logic [TAG_BITS-1:0]             out_tag,
  output logic [PRIORITY_BITS-1:0]        out_priority,
  output logic [spq_pkg::STATUS_BITS-1:0] out_status,
  output logic [CNT_W-1:0]                out_occupancy
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic                     busy_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     accept, full, empty;
  spq_ctl_t                 ctl;

  logic [TAG_BITS-1:0]      cell_tag  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic                     cell_lower [QUEUE_DEPTH];

  logic                     out_valid_r;
  logic [TAG_BITS-1:0]      out_tag_r, out_tag_nxt;
  logic [PRIORITY_BITS-1:0] out_prio_r, out_prio_nxt;
  spq_status_t              status_r, status_nxt;
  logic [CNT_W-1:0]         occ_r;

  assign accept  = start && !busy_r;
  assign full    = cnt_r == DEPTH_C;
  assign empty   = cnt_r == '0;
  assign ctl.enq = accept && (spq_op_t'(in_opcode) == OP_ENQ) && !full;
  assign ctl.deq = accept && (spq_op_t'(in_opcode) == OP_DEQ) && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                     l_lower;
      logic [TAG_BITS-1:0]      l_tag,  r_tag;
      logic [PRIORITY_BITS-1:0] l_prio, r_prio;

      if (gi == 0) begin : g_head
        assign l_lower = 1'b0;
        assign l_tag   = in_task_tag;
        assign l_prio  = in_task_priority;
      end else begin : g_mid
        assign l_lower = cell_lower[gi-1];
        assign l_tag   = cell_tag[gi-1];
        assign l_prio  = cell_prio[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign r_tag  = '0;
        assign r_prio = '0;
      end else begin : g_body
        assign r_tag  = cell_tag[gi+1];
        assign r_prio = cell_prio[gi+1];
      end

      spq_cell #(
        .IDX    (gi),
        .CNT_W  (CNT_W),
        .TAG_W  (TAG_BITS),
        .PRIO_W (PRIORITY_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (cnt_r),
        .new_tag    (in_task_tag),
        .new_prio   (in_task_priority),
        .left_lower (l_lower),
        .left_tag   (l_tag),
        .left_prio  (l_prio),
        .right_tag  (r_tag),
        .right_prio (r_prio),
        .lower      (cell_lower[gi]),
        .tag        (cell_tag[gi]),
        .prio       (cell_prio[gi])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt      = cnt_r;
    out_tag_nxt  = '0;
    out_prio_nxt = '0;
    status_nxt   = ST_OK;
    if (ctl.enq) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.deq) begin
      cnt_nxt      = cnt_r - CNT_W'(1);
      out_tag_nxt  = cell_tag[0];
      out_prio_nxt = cell_prio[0];
    end else if (accept && (spq_op_t'(in_opcode) == OP_ENQ)) begin
      status_nxt = ST_FULL;
    end else if (accept) begin
      status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tag_r  <= out_tag_nxt;
      out_prio_r <= out_prio_nxt;
      status_r   <= status_nxt;
      occ_r      <= cnt_nxt;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_tag       = out_tag_r;
  assign out_priority  = out_prio_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count beyond depth");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && occ_r == cnt_r)
    else $error("result strobe or occupancy wrong");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (occ_r == DEPTH_C && out_tag_r == '0))
    else $error("full status with wrong occupancy");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (occ_r == '0 && out_prio_r == '0))
    else $error("empty status with stale data");

endmodule
